FILE: sv/rmf_pkg.sv
// ----------------------------------------------------------------------------
// rmf_pkg: shared constants and types of the running median filter
// window size, sample width, sequencer states and inter-module structs
// ----------------------------------------------------------------------------
`default_nettype none

package rmf_pkg;

   // window length and sample width
   localparam int WINDOW = 3;
   localparam int SMP_W  = 16;

   // sorted store address and fill count widths
   localparam int IDX_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
   localparam int CNT_W = $clog2(WINDOW + 1);

   // zero marks an empty list slot, so samples are never below one
   localparam logic [SMP_W-1:0] STOPPER = '0;
   localparam logic [SMP_W-1:0] MIN_SMP = STOPPER + 1'b1;

   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(WINDOW);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(WINDOW - 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DROP_RD,
      ST_DROP_CMP,
      ST_INS_CHK,
      ST_INS_CMP,
      ST_MED_RD,
      ST_MED_HOLD
   } state_type;

   // sorted store access from the sequencer
   typedef struct packed {
      logic             wr_en;
      logic [IDX_W-1:0] wr_addr;
      logic [SMP_W-1:0] wr_data;
      logic             rd_en;
      logic [IDX_W-1:0] rd_addr;
   } ram_req_type;

   // shared comparator result
   typedef struct packed {
      logic eq;
      logic gt;
   } cmp_res_type;

   // sequencer status toward the top level
   typedef struct packed {
      logic             idle;
      logic             res_valid;
      logic [CNT_W-1:0] fill;
   } stat_type;

endpackage

`default_nettype wire

FILE: sv/rmf_ram.sv
// ----------------------------------------------------------------------------
// rmf_ram: generic single-port-write, single-port-read ram
// one write and one registered read per cycle; read data holds when idle
// ----------------------------------------------------------------------------
`default_nettype none

module rmf_ram #(
   parameter  int DATA_W = 16,
   parameter  int DEPTH  = 4,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [DATA_W-1:0] wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: sv/rmf_cmp.sv
// ----------------------------------------------------------------------------
// rmf_cmp: shared magnitude comparator
// one unsigned compare of a stored entry against the search key
// ----------------------------------------------------------------------------
`default_nettype none

module rmf_cmp (
   input  wire logic [rmf_pkg::SMP_W-1:0] entry,
   input  wire logic [rmf_pkg::SMP_W-1:0] key,
   output rmf_pkg::cmp_res_type           res
);

   always_comb begin
      res.eq = (entry == key);
      res.gt = (entry > key);
   end

endmodule

`default_nettype wire

FILE: sv/rmf_ctrl.sv
// ----------------------------------------------------------------------------
// rmf_ctrl: sequencer of the running median filter
// keeps the arrival ring, drops the oldest entry and inserts the new one in
// the sorted store one step at a time, then reads out the middle entry
// ----------------------------------------------------------------------------
`default_nettype none

module rmf_ctrl (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      start,
   input  wire logic [rmf_pkg::SMP_W-1:0] sample,
   input  wire logic                      res_take,
   input  wire rmf_pkg::cmp_res_type      cmp_res,
   input  wire logic [rmf_pkg::SMP_W-1:0] ram_rd_data,
   output rmf_pkg::ram_req_type           ram_req,
   output logic      [rmf_pkg::SMP_W-1:0] cmp_key,
   output rmf_pkg::stat_type              stat
);

   rmf_pkg::state_type            state_ff, state_in;
   logic [rmf_pkg::IDX_W-1:0]     idx_ff, idx_in;
   logic [rmf_pkg::CNT_W-1:0]     count_ff, count_in;
   logic [rmf_pkg::IDX_W-1:0]     pos_ff, pos_in;
   logic                          found_ff, found_in;
   logic [rmf_pkg::SMP_W-1:0]     key_ff, key_in;
   logic [rmf_pkg::SMP_W-1:0]     old_ff, old_in;
   logic [rmf_pkg::SMP_W-1:0]     ring_ff [rmf_pkg::WINDOW];
   logic [rmf_pkg::SMP_W-1:0]     ring_in [rmf_pkg::WINDOW];

   logic [rmf_pkg::IDX_W-1:0]     idx_dec;
   logic [rmf_pkg::CNT_W-1:0]     km1;
   logic [rmf_pkg::CNT_W-1:0]     med_pos;

   assign idx_dec = idx_ff - 1'b1;
   // ceil(k/2)-th largest sits at k-1-(k-1)/2 in ascending order
   assign km1     = count_ff - 1'b1;
   assign med_pos = km1 - (km1 >> 1);

   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      count_in = count_ff;
      pos_in   = pos_ff;
      found_in = found_ff;
      key_in   = key_ff;
      old_in   = old_ff;
      ring_in  = ring_ff;

      ram_req  = '0;
      cmp_key  = key_ff;

      stat.idle      = 1'b0;
      stat.res_valid = 1'b0;
      stat.fill      = count_ff;

      case (state_ff)
         rmf_pkg::ST_IDLE: begin
            stat.idle = 1'b1;
            if (start) begin
               key_in          = sample;
               old_in          = ring_ff[pos_ff];
               ring_in[pos_ff] = sample;
               pos_in   = (pos_ff == rmf_pkg::LAST_IDX) ? '0 : pos_ff + 1'b1;
               found_in = 1'b0;
               if (count_ff == rmf_pkg::FULL_CNT) begin
                  idx_in   = '0;
                  state_in = rmf_pkg::ST_DROP_RD;
               end else begin
                  idx_in   = count_ff[rmf_pkg::IDX_W-1:0];
                  state_in = rmf_pkg::ST_INS_CHK;
               end
            end
         end

         rmf_pkg::ST_DROP_RD: begin
            ram_req.rd_en   = 1'b1;
            ram_req.rd_addr = idx_ff;
            state_in        = rmf_pkg::ST_DROP_CMP;
         end

         rmf_pkg::ST_DROP_CMP: begin
            cmp_key = old_ff;
            // after the oldest value is found, each later entry moves down one
            if (found_ff) begin
               ram_req.wr_en   = 1'b1;
               ram_req.wr_addr = idx_dec;
               ram_req.wr_data = ram_rd_data;
            end else if (cmp_res.eq) begin
               found_in = 1'b1;
            end
            if (idx_ff == rmf_pkg::LAST_IDX) begin
               count_in = rmf_pkg::FULL_CNT - 1'b1;
               idx_in   = rmf_pkg::LAST_IDX;
               state_in = rmf_pkg::ST_INS_CHK;
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = rmf_pkg::ST_DROP_RD;
            end
         end

         rmf_pkg::ST_INS_CHK: begin
            if (idx_ff == '0) begin
               ram_req.wr_en   = 1'b1;
               ram_req.wr_addr = idx_ff;
               ram_req.wr_data = key_ff;
               count_in        = count_ff + 1'b1;
               state_in        = rmf_pkg::ST_MED_RD;
            end else begin
               ram_req.rd_en   = 1'b1;
               ram_req.rd_addr = idx_dec;
               state_in        = rmf_pkg::ST_INS_CMP;
            end
         end

         rmf_pkg::ST_INS_CMP: begin
            ram_req.wr_en   = 1'b1;
            ram_req.wr_addr = idx_ff;
            if (cmp_res.gt) begin
               // larger entry moves up one slot
               ram_req.wr_data = ram_rd_data;
               idx_in          = idx_dec;
               state_in        = rmf_pkg::ST_INS_CHK;
            end else begin
               ram_req.wr_data = key_ff;
               count_in        = count_ff + 1'b1;
               state_in        = rmf_pkg::ST_MED_RD;
            end
         end

         rmf_pkg::ST_MED_RD: begin
            ram_req.rd_en   = 1'b1;
            ram_req.rd_addr = med_pos[rmf_pkg::IDX_W-1:0];
            state_in        = rmf_pkg::ST_MED_HOLD;
         end

         rmf_pkg::ST_MED_HOLD: begin
            stat.res_valid = 1'b1;
            if (res_take) begin
               state_in = rmf_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = rmf_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rmf_pkg::ST_IDLE;
         idx_ff   <= '0;
         count_ff <= '0;
         pos_ff   <= '0;
         found_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
         count_ff <= count_in;
         pos_ff   <= pos_in;
         found_ff <= found_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff  <= key_in;
      old_ff  <= old_in;
      ring_ff <= ring_in;
   end

endmodule

`default_nettype wire

FILE: sv/running_median_filter_unit.sv
// ----------------------------------------------------------------------------
// running_median_filter_unit: sliding-window running median
// one median item out for every sample item in, over the last WINDOW samples
// ----------------------------------------------------------------------------
// steps: a full window first runs a drop search that shifts later entries down; the
//   insert walk moves larger entries up, writes the sample, then reads the middle entry
// one sample at a time: input waits until idle; a held output item stalls the sequencer
// reset: synchronous, active high; clears fill count, ring position, sequencer and
//   output valid, so the window starts empty; sorted store is never cleared
// ----------------------------------------------------------------------------
`default_nettype none

module running_median_filter_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   // input items
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [15:0] req_tdata,   // [15:0] sample
   // result items
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic      [15:0] rsp_tdata    // [15:0] median
);

   rmf_pkg::ram_req_type        ram_req;
   rmf_pkg::cmp_res_type        cmp_res;
   rmf_pkg::stat_type           stat;
   logic [rmf_pkg::SMP_W-1:0]   ram_rd_data;
   logic [rmf_pkg::SMP_W-1:0]   cmp_key;
   logic [rmf_pkg::SMP_W-1:0]   sample;
   logic                        start;
   logic                        res_take;

   logic                        rsp_valid_ff, rsp_valid_in;
   logic [rmf_pkg::SMP_W-1:0]   rsp_data_ff, rsp_data_in;

   // input side: take an item only while the sequencer waits for one
   assign req_tready = stat.idle;
   assign start      = req_tvalid & req_tready;

   // zero is the list stopper, so it enters as one
   assign sample = (req_tdata == rmf_pkg::STOPPER) ? rmf_pkg::MIN_SMP : req_tdata;

   // sorted store, in ascending order in its low entries
   rmf_ram #(
      .DATA_W (rmf_pkg::SMP_W),
      .DEPTH  (rmf_pkg::WINDOW)
   ) u_sorted (
      .clock   (clock),
      .wr_en   (ram_req.wr_en),
      .wr_addr (ram_req.wr_addr),
      .wr_data (ram_req.wr_data),
      .rd_en   (ram_req.rd_en),
      .rd_addr (ram_req.rd_addr),
      .rd_data (ram_rd_data)
   );

   // one comparator shared by the drop search and the insert walk
   rmf_cmp u_cmp (
      .entry (ram_rd_data),
      .key   (cmp_key),
      .res   (cmp_res)
   );

   rmf_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .sample      (sample),
      .res_take    (res_take),
      .cmp_res     (cmp_res),
      .ram_rd_data (ram_rd_data),
      .ram_req     (ram_req),
      .cmp_key     (cmp_key),
      .stat        (stat)
   );

   // output register: median moves here when the slot is free or emptying,
   // so the sequencer is back to idle while the item waits downstream
   always_comb begin
      res_take     = stat.res_valid & (~rsp_valid_ff | rsp_tready);
      rsp_valid_in = res_take | (rsp_valid_ff & ~rsp_tready);
      rsp_data_in  = res_take ? ram_rd_data : rsp_data_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

`ifndef SYNTHESIS
   // a median is never the stopper value
   a_no_zero_median: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata != rmf_pkg::STOPPER))
      else $error("median item carries the stopper value");

   // an accepted item keeps the sequencer busy on the next cycle
   a_busy_after_start: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("input taken again right after an item");

   // fill count stays within the window
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      stat.fill <= rmf_pkg::FULL_CNT)
      else $error("fill count beyond window");

   // a result handed over lands in the output register
   a_take_loads: assert property (@(posedge clock) disable iff (reset)
      res_take |=> rsp_tvalid)
      else $error("taken result not presented");
`endif

endmodule

`default_nettype wire
